[src/spq_pkg.sv]
// spq_pkg: transaction payload types, status and opcode codes, controller states
// and the command/status structs shared by the sorted priority queue modules.
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int KEY_W   = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  priority_req;
        logic        [TAG_W-1:0]  name_tag;
    } in_t;

    typedef struct packed {
        logic        [1:0]         status;
        logic signed [KEY_W-1:0]   out_priority;
        logic        [TAG_W-1:0]   out_tag;
        logic        [COUNT_W-1:0] count;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       compare;
        logic       insert;
        logic       remove;
        logic       write_result;
        logic [1:0] status;
    } spq_cmd_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic dup;
    } spq_stat_t;

endpackage

`default_nettype wire

[src/spq_datapath.sv]
// spq_datapath: row of sorted key/tag cells with per-cell compare flags,
// shift insert, shift-down remove and the result register.
// depends on spq_pkg
`default_nettype none

module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spq_pkg::in_t      in_data,
    input  wire spq_pkg::spq_cmd_t cmd,
    output spq_pkg::spq_stat_t     stat,
    output spq_pkg::out_t          out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                              op_reg;
    logic signed [spq_pkg::KEY_W-1:0]  key_in_reg;
    logic        [spq_pkg::TAG_W-1:0]  tag_in_reg;

    logic signed [spq_pkg::KEY_W-1:0]  key_reg  [DEPTH];
    logic signed [spq_pkg::KEY_W-1:0]  key_next [DEPTH];
    logic        [spq_pkg::TAG_W-1:0]  tag_reg  [DEPTH];
    logic        [spq_pkg::TAG_W-1:0]  tag_next [DEPTH];

    logic [DEPTH-1:0] lt_reg;
    logic [DEPTH-1:0] lt_next;
    logic [DEPTH-1:0] eq_reg;
    logic [DEPTH-1:0] eq_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    spq_pkg::out_t result_reg;
    spq_pkg::out_t result_next;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            always_comb
            begin
                lt_next[i] = (CW'(i) < count_reg) && (key_reg[i] < key_in_reg);
                eq_next[i] = (CW'(i) < count_reg) && (key_reg[i] == key_in_reg);
            end

            if (i == 0)
            begin : g_head
                always_comb
                begin
                    key_next[i] = key_reg[i];
                    tag_next[i] = tag_reg[i];
                    if (cmd.insert && !lt_reg[i])
                    begin
                        key_next[i] = key_in_reg;
                        tag_next[i] = tag_in_reg;
                    end
                    else if (cmd.remove)
                    begin
                        key_next[i] = key_reg[i+1];
                        tag_next[i] = tag_reg[i+1];
                    end
                end
            end
            else if (i == DEPTH - 1)
            begin : g_tail
                always_comb
                begin
                    key_next[i] = key_reg[i];
                    tag_next[i] = tag_reg[i];
                    if (cmd.insert && !lt_reg[i])
                    begin
                        key_next[i] = lt_reg[i-1] ? key_in_reg : key_reg[i-1];
                        tag_next[i] = lt_reg[i-1] ? tag_in_reg : tag_reg[i-1];
                    end
                end
            end
            else
            begin : g_mid
                always_comb
                begin
                    key_next[i] = key_reg[i];
                    tag_next[i] = tag_reg[i];
                    if (cmd.insert && !lt_reg[i])
                    begin
                        key_next[i] = lt_reg[i-1] ? key_in_reg : key_reg[i-1];
                        tag_next[i] = lt_reg[i-1] ? tag_in_reg : tag_reg[i-1];
                    end
                    else if (cmd.remove)
                    begin
                        key_next[i] = key_reg[i+1];
                        tag_next[i] = tag_reg[i+1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                key_reg[i] <= key_next[i];
                tag_reg[i] <= tag_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.write_result)
        begin
            result_next.status       = cmd.status;
            result_next.out_priority = cmd.remove ? key_reg[0] : '0;
            result_next.out_tag      = cmd.remove ? tag_reg[0] : '0;
            result_next.count        = spq_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_data.opcode;
            key_in_reg <= in_data.priority_req;
            tag_in_reg <= in_data.name_tag;
        end
        if (cmd.compare)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        stat.is_remove = (op_reg == spq_pkg::OP_REMOVE);
        stat.full      = (count_reg == CW'(DEPTH));
        stat.empty     = (count_reg == '0);
        stat.dup       = |eq_reg;
    end

    assign out_data = result_reg;

endmodule

`default_nettype wire

[src/spq_ctrl.sv]
// spq_ctrl: transaction sequencer for the sorted priority queue; decides the
// operation outcome and holds the output valid flag.
// depends on spq_pkg
`default_nettype none

module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t       cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.status = spq_pkg::ST_OK;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = spq_pkg::S_COMPARE;
                end
            end
            spq_pkg::S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = spq_pkg::S_EXEC;
            end
            spq_pkg::S_EXEC:
            begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_result = 1'b1;
                    state_next       = spq_pkg::S_IDLE;
                    if (stat.is_remove)
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.remove = 1'b1;
                        end
                    end
                    else if (stat.full)
                    begin
                        cmd.status = spq_pkg::ST_FULL;
                    end
                    else if (stat.dup)
                    begin
                        cmd.status = spq_pkg::ST_DUP;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !out_ready) || cmd.write_result;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// sorted_priority_queue: top level, joins the sequencer and the cell datapath.
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//   channel   handshake              payload
//   input     in_valid / in_ready    in_data  (spq_pkg::in_t)
//   output    out_valid / out_ready  out_data (spq_pkg::out_t)
//
// a transaction runs as capture, parallel compare of all cells into
// registered flags, then shift insert or shift-down remove with the result write
// a new input is taken while the previous result waits on the output register
// the execute step holds while the output register is still full
// reset empties the queue at once, the cells themselves are not cleared
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire spq_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output spq_pkg::out_t      out_data
);

    spq_pkg::spq_cmd_t  cmd;
    spq_pkg::spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
